// ----- hw/rtl/tash_pkg.sv -----
package tash_pkg;

   localparam int LEN_W = 17;
   localparam int PER_W = 16;
   localparam int CMD_W = 2;
   localparam int DIR_W = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam int PHASE_W = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HOME = 2'd2;

   // direction codes
   localparam logic [DIR_W-1:0] HEADING_NONE  = 3'd0;
   localparam logic [DIR_W-1:0] HEADING_UP    = 3'd1;
   localparam logic [DIR_W-1:0] HEADING_LEFT  = 3'd2;
   localparam logic [DIR_W-1:0] HEADING_DOWN  = 3'd3;
   localparam logic [DIR_W-1:0] HEADING_RIGHT = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SEARCH_PERIOD  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACKOFF_PERIOD = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_SEARCH_LENGTH  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACKOFF_LENGTH = 2'd3;

   localparam logic [PER_W-1:0] SEARCH_PERIOD_RST  = 16'd800;
   localparam logic [PER_W-1:0] BACKOFF_PERIOD_RST = 16'd200;
   localparam logic [LEN_W-1:0] SEARCH_LENGTH_RST  = 17'd100000;
   localparam logic [LEN_W-1:0] BACKOFF_LENGTH_RST = 17'd1000;
   localparam logic [PER_W-1:0] COMPARE_RST        = 16'd400;

   // homing phase codes as seen on the result beat
   localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_CODE_XSEARCH = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_CODE_XBACK   = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_CODE_YSEARCH = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_CODE_YBACK   = 3'd4;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_XSEARCH = 5'b00010,
      PH_XBACK   = 5'b00100,
      PH_YSEARCH = 5'b01000,
      PH_YBACK   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic dir;
      logic pulse;
      logic run;
      logic busy;
   } axis_flags_type;

   // flags of a freshly started move; dir pin is high for one direction code
   function automatic axis_flags_type start_flags(input logic [DIR_W-1:0] dir,
                                                  input logic [DIR_W-1:0] pin_dir);
      axis_flags_type f;
      f.busy  = 1'b1;
      f.run   = 1'b1;
      f.pulse = (dir != HEADING_NONE);
      f.dir   = (dir == pin_dir);
      return f;
   endfunction

   function automatic logic [PHASE_W-1:0] phase_code(input phase_type ph);
      logic [PHASE_W-1:0] c;
      case (ph)
         PH_IDLE:    c = PHASE_CODE_IDLE;
         PH_XSEARCH: c = PHASE_CODE_XSEARCH;
         PH_XBACK:   c = PHASE_CODE_XBACK;
         PH_YSEARCH: c = PHASE_CODE_YSEARCH;
         PH_YBACK:   c = PHASE_CODE_YBACK;
         default:    c = PHASE_CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage

// ----- hw/rtl/two_axis_stepper_homing.sv -----
// Two-axis step/direction generator with endstop homing. Every request beat is
// one item: a timer tick, a move start for one axis, or a homing start; every
// accepted beat yields exactly one response beat carrying the pin levels, busy
// flags and homing phase after that item. The whole update is one pass of logic
// from the accepted beat and the axis state into the response register, so a
// beat can be taken every cycle unless the response is held. The request side
// stays ready while the response register is empty or being drained the same
// cycle. Each tick advances a per-axis compare timer (a match every compare+1
// ticks); two matches make one step pulse; the move ends at its target count.
// A pressed endstop at a completed pulse stops both axes unless suppressed
// (suppression holds during back-offs). Homing: X search left, X back-off
// right, Y search up, Y back-off down. Move commands to a busy axis are dropped.
// Config registers are written via csr_*; the user must do so only while the
// block is idle, which the block itself does not enforce.
module two_axis_stepper_homing (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: [1:0] command, [2] axis, [19:3] length, [35:20] period,
   //          [38:36] direction, [39] x_limit, [40] y_limit, rest zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tash_pkg::REQ_DATA_W-1:0]      req_tdata,
   // response: [0] x_step, [1] x_dir, [2] y_step, [3] y_dir, [4] x_busy,
   //           [5] y_busy, [8:6] homing_phase, rest zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tash_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // register write port
   input  logic                                 csr_wen,
   input  logic [tash_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [tash_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // request fields
   logic [tash_pkg::CMD_W-1:0] command;
   logic                       axis;
   logic [tash_pkg::LEN_W-1:0] length;
   logic [tash_pkg::PER_W-1:0] period;
   logic [tash_pkg::DIR_W-1:0] direction;
   logic                       x_limit;
   logic                       y_limit;

   assign command   = req_tdata[1:0];
   assign axis      = req_tdata[2];
   assign length    = req_tdata[19:3];
   assign period    = req_tdata[35:20];
   assign direction = req_tdata[38:36];
   assign x_limit   = req_tdata[39];
   assign y_limit   = req_tdata[40];

   // config registers
   logic [tash_pkg::PER_W-1:0] search_period_ff;
   logic [tash_pkg::PER_W-1:0] backoff_period_ff;
   logic [tash_pkg::LEN_W-1:0] search_length_ff;
   logic [tash_pkg::LEN_W-1:0] backoff_length_ff;

   // axis state
   logic [tash_pkg::PER_W-1:0] x_timer_ff,   x_timer_in;
   logic [tash_pkg::PER_W-1:0] y_timer_ff,   y_timer_in;
   logic                       x_half_ff,    x_half_in;
   logic                       y_half_ff,    y_half_in;
   logic [tash_pkg::LEN_W-1:0] x_done_ff,    x_done_in;
   logic [tash_pkg::LEN_W-1:0] y_done_ff,    y_done_in;
   logic [tash_pkg::LEN_W-1:0] x_target_ff,  x_target_in;
   logic [tash_pkg::LEN_W-1:0] y_target_ff,  y_target_in;
   logic [tash_pkg::PER_W-1:0] x_compare_ff, x_compare_in;
   logic [tash_pkg::PER_W-1:0] y_compare_ff, y_compare_in;
   tash_pkg::axis_flags_type   x_flags_ff,   x_flags_in;
   tash_pkg::axis_flags_type   y_flags_ff,   y_flags_in;
   logic                       x_step_ff,    x_step_in;
   logic                       y_step_ff,    y_step_in;
   logic                       suppress_ff,  suppress_in;
   tash_pkg::phase_type        phase_ff,     phase_in;

   // response register
   logic                            rsp_valid_ff;
   logic [tash_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic x_match, y_match;
   logic x_stop;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign x_match = (x_timer_ff >= x_compare_ff);
   assign y_match = (y_timer_ff >= y_compare_ff);

   // whole per-item update, written in the order the axes are served
   always_comb begin
      x_timer_in   = x_timer_ff;
      y_timer_in   = y_timer_ff;
      x_half_in    = x_half_ff;
      y_half_in    = y_half_ff;
      x_done_in    = x_done_ff;
      y_done_in    = y_done_ff;
      x_target_in  = x_target_ff;
      y_target_in  = y_target_ff;
      x_compare_in = x_compare_ff;
      y_compare_in = y_compare_ff;
      x_flags_in   = x_flags_ff;
      y_flags_in   = y_flags_ff;
      x_step_in    = x_step_ff;
      y_step_in    = y_step_ff;
      suppress_in  = suppress_ff;
      phase_in     = phase_ff;
      x_stop       = 1'b0;

      case (command)
         tash_pkg::CMD_TICK: begin
            x_timer_in = x_match ? '0 : tash_pkg::PER_W'(x_timer_ff + 1'b1);
            y_timer_in = y_match ? '0 : tash_pkg::PER_W'(y_timer_ff + 1'b1);
            // x first; its limit stop keeps y from being served
            if (x_match && x_flags_ff.run) begin
               if (!x_half_ff) begin
                  if (x_flags_ff.pulse) x_step_in = 1'b1;
                  x_half_in = 1'b1;
               end else begin
                  if (x_flags_ff.pulse) x_step_in = 1'b0;
                  x_half_in = 1'b0;
                  x_done_in = tash_pkg::LEN_W'(x_done_ff + 1'b1);
                  if (x_done_in >= x_target_ff) begin
                     x_done_in       = '0;
                     x_flags_in.busy = 1'b0;
                     x_flags_in.run  = 1'b0;
                  end
                  if (x_limit && !suppress_ff) begin
                     x_stop          = 1'b1;
                     x_flags_in.busy = 1'b0;
                     x_flags_in.run  = 1'b0;
                     y_flags_in.busy = 1'b0;
                     y_flags_in.run  = 1'b0;
                  end
               end
            end
            if (y_match && y_flags_ff.run && !x_stop) begin
               if (!y_half_ff) begin
                  if (y_flags_ff.pulse) y_step_in = 1'b1;
                  y_half_in = 1'b1;
               end else begin
                  if (y_flags_ff.pulse) y_step_in = 1'b0;
                  y_half_in = 1'b0;
                  y_done_in = tash_pkg::LEN_W'(y_done_ff + 1'b1);
                  if (y_done_in >= y_target_ff) begin
                     y_done_in       = '0;
                     y_flags_in.busy = 1'b0;
                     y_flags_in.run  = 1'b0;
                  end
                  if (y_limit && !suppress_ff) begin
                     x_flags_in.busy = 1'b0;
                     x_flags_in.run  = 1'b0;
                     y_flags_in.busy = 1'b0;
                     y_flags_in.run  = 1'b0;
                  end
               end
            end
         end
         tash_pkg::CMD_MOVE: begin
            if (!axis && !x_flags_ff.busy) begin
               x_target_in  = length;
               x_compare_in = period;
               x_flags_in   = tash_pkg::start_flags(direction, tash_pkg::HEADING_LEFT);
            end else if (axis && !y_flags_ff.busy) begin
               y_target_in  = length;
               y_compare_in = period;
               y_flags_in   = tash_pkg::start_flags(direction, tash_pkg::HEADING_UP);
            end
         end
         tash_pkg::CMD_HOME: begin
            if (phase_ff == tash_pkg::PH_IDLE && !y_flags_ff.busy) begin
               // a busy x drops the search; the sequence then waits on x
               if (!x_flags_ff.busy) begin
                  x_target_in  = search_length_ff;
                  x_compare_in = search_period_ff;
                  x_flags_in   = tash_pkg::start_flags(tash_pkg::HEADING_LEFT,
                                                       tash_pkg::HEADING_LEFT);
               end
               phase_in = tash_pkg::PH_XSEARCH;
            end
         end
         default: begin
         end
      endcase

      // homing sequencer, sees the state after this item's command
      case (phase_in)
         tash_pkg::PH_XSEARCH: begin
            if (!x_flags_in.busy) begin
               suppress_in  = 1'b1;
               x_done_in    = '0;
               x_target_in  = backoff_length_ff;
               x_compare_in = backoff_period_ff;
               x_flags_in   = tash_pkg::start_flags(tash_pkg::HEADING_RIGHT,
                                                    tash_pkg::HEADING_LEFT);
               phase_in     = tash_pkg::PH_XBACK;
            end
         end
         tash_pkg::PH_XBACK: begin
            if (!x_flags_in.busy) begin
               suppress_in = 1'b0;
               if (!y_flags_in.busy) begin
                  y_target_in  = search_length_ff;
                  y_compare_in = search_period_ff;
                  y_flags_in   = tash_pkg::start_flags(tash_pkg::HEADING_UP,
                                                       tash_pkg::HEADING_UP);
               end
               phase_in = tash_pkg::PH_YSEARCH;
            end
         end
         tash_pkg::PH_YSEARCH: begin
            if (!y_flags_in.busy) begin
               suppress_in  = 1'b1;
               y_done_in    = '0;
               y_target_in  = backoff_length_ff;
               y_compare_in = backoff_period_ff;
               y_flags_in   = tash_pkg::start_flags(tash_pkg::HEADING_DOWN,
                                                    tash_pkg::HEADING_UP);
               phase_in     = tash_pkg::PH_YBACK;
            end
         end
         tash_pkg::PH_YBACK: begin
            if (!y_flags_in.busy) begin
               suppress_in = 1'b0;
               phase_in    = tash_pkg::PH_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in      = '0;
      rsp_data_in[0]   = x_step_in;
      rsp_data_in[1]   = x_flags_in.dir;
      rsp_data_in[2]   = y_step_in;
      rsp_data_in[3]   = y_flags_in.dir;
      rsp_data_in[4]   = x_flags_in.busy;
      rsp_data_in[5]   = y_flags_in.busy;
      rsp_data_in[8:6] = tash_pkg::phase_code(phase_in);
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         search_period_ff  <= tash_pkg::SEARCH_PERIOD_RST;
         backoff_period_ff <= tash_pkg::BACKOFF_PERIOD_RST;
         search_length_ff  <= tash_pkg::SEARCH_LENGTH_RST;
         backoff_length_ff <= tash_pkg::BACKOFF_LENGTH_RST;
      end else if (csr_wen) begin
         case (csr_addr)
            tash_pkg::CSR_SEARCH_PERIOD:
               search_period_ff <= csr_wdata[tash_pkg::PER_W-1:0];
            tash_pkg::CSR_BACKOFF_PERIOD:
               backoff_period_ff <= csr_wdata[tash_pkg::PER_W-1:0];
            tash_pkg::CSR_SEARCH_LENGTH:
               search_length_ff <= csr_wdata[tash_pkg::LEN_W-1:0];
            tash_pkg::CSR_BACKOFF_LENGTH:
               backoff_length_ff <= csr_wdata[tash_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // axis state advances only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         x_timer_ff   <= '0;
         y_timer_ff   <= '0;
         x_half_ff    <= 1'b0;
         y_half_ff    <= 1'b0;
         x_done_ff    <= '0;
         y_done_ff    <= '0;
         x_target_ff  <= '0;
         y_target_ff  <= '0;
         x_compare_ff <= tash_pkg::COMPARE_RST;
         y_compare_ff <= tash_pkg::COMPARE_RST;
         x_flags_ff   <= '0;
         y_flags_ff   <= '0;
         x_step_ff    <= 1'b0;
         y_step_ff    <= 1'b0;
         suppress_ff  <= 1'b0;
         phase_ff     <= tash_pkg::PH_IDLE;
      end else if (accept) begin
         x_timer_ff   <= x_timer_in;
         y_timer_ff   <= y_timer_in;
         x_half_ff    <= x_half_in;
         y_half_ff    <= y_half_in;
         x_done_ff    <= x_done_in;
         y_done_ff    <= y_done_in;
         x_target_ff  <= x_target_in;
         y_target_ff  <= y_target_in;
         x_compare_ff <= x_compare_in;
         y_compare_ff <= y_compare_in;
         x_flags_ff   <= x_flags_in;
         y_flags_ff   <= y_flags_in;
         x_step_ff    <= x_step_in;
         y_step_ff    <= y_step_in;
         suppress_ff  <= suppress_in;
         phase_ff     <= phase_in;
      end
   end

   // response register: loads on accept, empties when drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import tash_pkg::*;

   localparam logic AX_X = 1'b0;
   localparam logic AX_Y = 1'b1;
   // watchdog limit, set with room for a slow run with every beat held off on both sides
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SEGMENT_BEATS = 200;

   // codes the package leaves unnamed: a command and a direction the block must tolerate
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [DIR_W-1:0] HEADING_UNKNOWN = 3'd7;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;
   localparam logic [PER_W-1:0] PER_MAX = '1;

   typedef struct {
      logic [CMD_W-1:0] command;
      logic             axis;
      logic [LEN_W-1:0] length;
      logic [PER_W-1:0] period;
      logic [DIR_W-1:0] direction;
      logic             x_limit;
      logic             y_limit;
   } motion_cmd_type;

   // pin picture after one command, x_step in bit 0 as on rsp_tdata
   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               y_busy;
      logic               x_busy;
      logic               y_dir;
      logic               y_step;
      logic               x_dir;
      logic               x_step;
   } pin_state_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   two_axis_stepper_homing u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Motion predictor: our own copy of both axes, the homing sequencer and the registers
   // ---------------------------------------------------------------------------------
   logic [PER_W-1:0]   cfg_search_per;
   logic [PER_W-1:0]   cfg_back_per;
   logic [LEN_W-1:0]   cfg_search_len;
   logic [LEN_W-1:0]   cfg_back_len;

   logic [PER_W-1:0]   ax_timer   [2];
   logic [PER_W-1:0]   ax_compare [2];
   logic [LEN_W-1:0]   ax_done    [2];
   logic [LEN_W-1:0]   ax_target  [2];
   logic               ax_half    [2];   // first match of a pulse seen
   logic               ax_busy    [2];
   logic               ax_run     [2];
   logic               ax_pulse   [2];   // pins driven (direction was not stop)
   logic               ax_dpin    [2];
   logic               step_pin   [2];
   logic               limit_hold;       // endstop checks off during back-offs
   logic [PHASE_W-1:0] home_phase;

   int unsigned        homing_runs = 0;
   int unsigned        limit_stops = 0;

   task automatic reset_predictor();
      cfg_search_per = SEARCH_PERIOD_RST;
      cfg_back_per   = BACKOFF_PERIOD_RST;
      cfg_search_len = SEARCH_LENGTH_RST;
      cfg_back_len   = BACKOFF_LENGTH_RST;
      for (int a = 0; a < 2; a++) begin
         ax_timer[a]   = '0;
         ax_compare[a] = COMPARE_RST;
         ax_done[a]    = '0;
         ax_target[a]  = '0;
         ax_half[a]    = 1'b0;
         ax_busy[a]    = 1'b0;
         ax_run[a]     = 1'b0;
         ax_pulse[a]   = 1'b0;
         ax_dpin[a]    = 1'b0;
         step_pin[a]   = 1'b0;
      end
      limit_hold = 1'b0;
      home_phase = PHASE_CODE_IDLE;
   endtask

   // a busy axis drops the move; x dir pin means left, y dir pin means up
   function automatic void launch_move(input logic ax, input logic [LEN_W-1:0] len,
                                       input logic [PER_W-1:0] per,
                                       input logic [DIR_W-1:0] dir);
      if (ax_busy[ax]) return;
      ax_target[ax]  = len;
      ax_compare[ax] = per;
      ax_busy[ax]    = 1'b1;
      ax_run[ax]     = 1'b1;
      ax_pulse[ax]   = (dir != HEADING_NONE);
      ax_dpin[ax]    = (ax == AX_Y) ? (dir == HEADING_UP) : (dir == HEADING_LEFT);
   endfunction

   // one timer match of a running axis; true when a pressed endstop must stop both
   function automatic logic serve_match(input logic ax, input logic limit);
      if (!ax_half[ax]) begin
         if (ax_pulse[ax]) step_pin[ax] = 1'b1;
         ax_half[ax] = 1'b1;
         return 1'b0;
      end
      if (ax_pulse[ax]) step_pin[ax] = 1'b0;
      ax_half[ax] = 1'b0;
      ax_done[ax] = ax_done[ax] + 1'b1;
      if (ax_done[ax] >= ax_target[ax]) begin
         ax_done[ax] = '0;
         ax_busy[ax] = 1'b0;
         ax_run[ax]  = 1'b0;
      end
      return limit && !limit_hold;
   endfunction

   // limit stop: both axes lose busy and run, step counts and pins are kept
   function automatic void halt_axes();
      for (int a = 0; a < 2; a++) begin
         ax_busy[a] = 1'b0;
         ax_run[a]  = 1'b0;
      end
      limit_stops++;
   endfunction

   function automatic pin_state_type step_axes(input motion_cmd_type c);
      logic          x_hit;
      logic          y_hit;
      pin_state_type p;
      case (c.command)
         CMD_TICK: begin
            x_hit = ax_timer[AX_X] >= ax_compare[AX_X];
            y_hit = ax_timer[AX_Y] >= ax_compare[AX_Y];
            ax_timer[AX_X] = x_hit ? '0 : ax_timer[AX_X] + 1'b1;
            ax_timer[AX_Y] = y_hit ? '0 : ax_timer[AX_Y] + 1'b1;
            // x first; a stop raised by x leaves y unserved this tick
            if (x_hit && ax_run[AX_X]) begin
               if (serve_match(AX_X, c.x_limit)) halt_axes();
            end
            if (y_hit && ax_run[AX_Y]) begin
               if (serve_match(AX_Y, c.y_limit)) halt_axes();
            end
         end
         CMD_MOVE: launch_move(c.axis, c.length, c.period, c.direction);
         CMD_HOME: begin
            if (home_phase == PHASE_CODE_IDLE && !ax_busy[AX_Y]) begin
               launch_move(AX_X, cfg_search_len, cfg_search_per, HEADING_LEFT);
               home_phase = PHASE_CODE_XSEARCH;
            end
         end
         default: ;
      endcase

      // sequencer moves on once the axis of the current phase is idle
      if (home_phase == PHASE_CODE_XSEARCH && !ax_busy[AX_X]) begin
         limit_hold = 1'b1;
         ax_done[AX_X] = '0;
         launch_move(AX_X, cfg_back_len, cfg_back_per, HEADING_RIGHT);
         home_phase = PHASE_CODE_XBACK;
      end else if (home_phase == PHASE_CODE_XBACK && !ax_busy[AX_X]) begin
         limit_hold = 1'b0;
         launch_move(AX_Y, cfg_search_len, cfg_search_per, HEADING_UP);
         home_phase = PHASE_CODE_YSEARCH;
      end else if (home_phase == PHASE_CODE_YSEARCH && !ax_busy[AX_Y]) begin
         limit_hold = 1'b1;
         ax_done[AX_Y] = '0;
         launch_move(AX_Y, cfg_back_len, cfg_back_per, HEADING_DOWN);
         home_phase = PHASE_CODE_YBACK;
      end else if (home_phase == PHASE_CODE_YBACK && !ax_busy[AX_Y]) begin
         limit_hold = 1'b0;
         home_phase = PHASE_CODE_IDLE;
         homing_runs++;
      end

      p.x_step = step_pin[AX_X];
      p.x_dir  = ax_dpin[AX_X];
      p.y_step = step_pin[AX_Y];
      p.y_dir  = ax_dpin[AX_Y];
      p.x_busy = ax_busy[AX_X];
      p.y_busy = ax_busy[AX_Y];
      p.phase  = home_phase;
      return p;
   endfunction

   // ---------------------------------------------------------------------------------
   // Command driver: pops pending commands and leaves a random gap after each beat,
   // with quiet stretches where the gap is always zero
   // ---------------------------------------------------------------------------------
   motion_cmd_type cmd_q[$];
   motion_cmd_type cmd_cur;
   pin_state_type  pin_state_q[$];
   int unsigned    cmd_gap = 0;
   logic           drv_quiet = 1'b0;
   int unsigned    beats_queued = 0;
   int unsigned    beats_taken = 0;
   int unsigned    beats_made = 0;     // commands the block acts on, unknown ones left out

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            pin_state_q.push_back(step_axes(cmd_cur));
            beats_taken++;
            if ($urandom_range(0, 47) == 0) drv_quiet = !drv_quiet;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_gap > 0) begin
               cmd_gap--;
               req_tvalid <= 1'b0;
            end else if (cmd_q.size() > 0) begin
               cmd_cur = cmd_q.pop_front();
               req_tdata <= {7'd0, cmd_cur.y_limit, cmd_cur.x_limit, cmd_cur.direction,
                             cmd_cur.period, cmd_cur.length, cmd_cur.axis, cmd_cur.command};
               req_tvalid <= 1'b1;
               cmd_gap = drv_quiet ? 0 : $urandom_range(0, 5);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Pin monitor: stalls for a random time after each result beat, checks against the oldest
   // predicted pin state
   // ---------------------------------------------------------------------------------
   int unsigned rsp_stall = 0;
   logic        mon_quiet = 1'b0;
   int unsigned err_cnt = 0;
   int unsigned results_checked = 0;

   task automatic cmp_field(input string name, input int unsigned want,
                            input int unsigned got);
      if (want != got) begin
         $display("%0t ns: result %0d %s expected %0d actual %0d", $time, results_checked,
                  name, want, got);
         err_cnt++;
      end
   endtask

   task automatic check_result(input logic [RSP_DATA_W-1:0] raw);
      pin_state_type want;
      pin_state_type got;
      got = raw[$bits(pin_state_type)-1:0];
      if (pin_state_q.size() == 0) begin
         $display("%0t ns: result beat expected none actual %h", $time, raw);
         err_cnt++;
         return;
      end
      want = pin_state_q.pop_front();
      cmp_field("x_step", 32'(want.x_step), 32'(got.x_step));
      cmp_field("x_dir", 32'(want.x_dir), 32'(got.x_dir));
      cmp_field("y_step", 32'(want.y_step), 32'(got.y_step));
      cmp_field("y_dir", 32'(want.y_dir), 32'(got.y_dir));
      cmp_field("x_busy", 32'(want.x_busy), 32'(got.x_busy));
      cmp_field("y_busy", 32'(want.y_busy), 32'(got.y_busy));
      cmp_field("homing_phase", 32'(want.phase), 32'(got.phase));
      cmp_field("padding", 0, 32'(raw[RSP_DATA_W-1:$bits(pin_state_type)]));
      results_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
            rsp_stall = mon_quiet ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 47) == 0) mon_quiet = !mon_quiet;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   int unsigned cycle_cnt = 0;
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("%0t ns: timeout, %0d results still expected", $time, pin_state_q.size());
         $display("tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   task automatic push_cmd(input logic [CMD_W-1:0] command, input logic axis,
                           input logic [LEN_W-1:0] length, input logic [PER_W-1:0] period,
                           input logic [DIR_W-1:0] direction, input logic x_limit,
                           input logic y_limit);
      motion_cmd_type c;
      c.command   = command;
      c.axis      = axis;
      c.length    = length;
      c.period    = period;
      c.direction = direction;
      c.x_limit   = x_limit;
      c.y_limit   = y_limit;
      cmd_q.push_back(c);
      beats_queued++;
      if (command != CMD_UNKNOWN) beats_made++;
   endtask

   // ticks with random junk in the unused fields; endstops pressed about 1 in odds+1
   task automatic push_ticks(input int unsigned n, input int unsigned odds);
      for (int unsigned i = 0; i < n; i++) begin
         push_cmd(CMD_TICK, 1'($urandom), LEN_W'($urandom), PER_W'($urandom),
                  DIR_W'($urandom),
                  $urandom_range(0, odds) == 0, $urandom_range(0, odds) == 0);
      end
   endtask

   // register writes back to back, wen dropped once after the last one
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SEARCH_PERIOD:  cfg_search_per = val[PER_W-1:0];
         CSR_BACKOFF_PERIOD: cfg_back_per   = val[PER_W-1:0];
         CSR_SEARCH_LENGTH:  cfg_search_len = val[LEN_W-1:0];
         CSR_BACKOFF_LENGTH: cfg_back_len   = val[LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_profile(input logic [PER_W-1:0] sp, input logic [PER_W-1:0] bp,
                               input logic [LEN_W-1:0] sl, input logic [LEN_W-1:0] bl);
      write_reg(CSR_SEARCH_PERIOD, CSR_DATA_W'(sp));
      write_reg(CSR_BACKOFF_PERIOD, CSR_DATA_W'(bp));
      write_reg(CSR_SEARCH_LENGTH, sl);
      write_reg(CSR_BACKOFF_LENGTH, bl);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // sender holds off until every result is back
   task automatic wait_idle();
      while (beats_taken != beats_queued || pin_state_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly whole homing runs and move+tick bursts, some noise and broken sequences
   task automatic random_traffic(input int unsigned target);
      int unsigned      start_cnt;
      int unsigned      r;
      int unsigned      n;
      logic [LEN_W-1:0] len;
      logic [PER_W-1:0] per;
      start_cnt = beats_made;
      while (beats_made - start_cnt < target) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            push_cmd(CMD_HOME, 1'($urandom), LEN_W'($urandom), PER_W'($urandom),
                     DIR_W'($urandom), 1'b0, 1'b0);
            push_ticks($urandom_range(8, 70), $urandom_range(4, 20));
         end else if (r < 75) begin
            n = $urandom_range(1, 2);
            for (int unsigned i = 0; i < n; i++) begin
               // long or slow moves now and then; endstop stops get them out again
               len = ($urandom_range(0, 15) == 0) ? LEN_W'($urandom)
                                                  : LEN_W'($urandom_range(0, 6));
               per = ($urandom_range(0, 15) == 0) ? PER_W'($urandom)
                                                  : PER_W'($urandom_range(0, 4));
               push_cmd(CMD_MOVE, 1'($urandom), len, per, DIR_W'($urandom_range(0, 7)),
                        1'($urandom), 1'($urandom));
            end
            push_ticks($urandom_range(4, 40), 9);
         end else if (r < 90) begin
            n = $urandom_range(1, 6);
            for (int unsigned i = 0; i < n; i++) begin
               push_cmd(CMD_W'($urandom_range(0, 3)), 1'($urandom), LEN_W'($urandom),
                        PER_W'($urandom), DIR_W'($urandom), 1'($urandom), 1'($urandom));
            end
         end else begin
            // commands thrown in mid-run: homing over a busy axis, moves over homing
            n = $urandom_range(5, 20);
            for (int unsigned i = 0; i < n; i++) begin
               push_cmd(CMD_W'($urandom_range(0, 2)), 1'($urandom),
                        LEN_W'($urandom_range(0, 6)), PER_W'($urandom_range(0, 4)),
                        DIR_W'($urandom_range(0, 7)),
                        $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0);
            end
         end
      end
   endtask

   initial begin
      reset_predictor();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset register values (no homing: default searches are far too long)
      push_cmd(CMD_UNKNOWN, 1'b1, LEN_MAX, PER_MAX, HEADING_UNKNOWN, 1'b1, 1'b1);
      push_cmd(CMD_TICK, 1'b0, '0, '0, HEADING_NONE, 1'b0, 1'b0);
      // zero length, direction stop: one silent pulse then done
      push_cmd(CMD_MOVE, AX_X, '0, '0, HEADING_NONE, 1'b0, 1'b0);
      push_cmd(CMD_MOVE, AX_Y, LEN_MAX, PER_MAX, HEADING_UP, 1'b0, 1'b0);
      push_cmd(CMD_MOVE, AX_X, 17'd5, '0, HEADING_RIGHT, 1'b0, 1'b0);   // x busy, dropped
      push_cmd(CMD_TICK, 1'b0, '0, '0, HEADING_NONE, 1'b0, 1'b0);
      // x pulse completes on a pressed endstop: stops the long y move as well
      push_cmd(CMD_TICK, 1'b0, '0, '0, HEADING_NONE, 1'b1, 1'b0);
      push_cmd(CMD_MOVE, AX_X, LEN_MAX, '0, HEADING_UNKNOWN, 1'b0, 1'b0);
      // y timer is above the new compare of zero, so it matches at once
      push_cmd(CMD_MOVE, AX_Y, 17'd1, '0, HEADING_DOWN, 1'b0, 1'b0);
      push_cmd(CMD_TICK, 1'b0, '0, '0, HEADING_NONE, 1'b0, 1'b0);
      // both match, x stops both: y stays unserved with its step pin high
      push_cmd(CMD_TICK, 1'b0, '0, '0, HEADING_NONE, 1'b1, 1'b1);
      push_cmd(CMD_MOVE, AX_Y, '0, 16'd2, HEADING_LEFT, 1'b0, 1'b0);
      push_ticks(4, 0);
      push_cmd(CMD_MOVE, AX_X, 17'd2, 16'd1, HEADING_RIGHT, 1'b0, 1'b0);
      push_cmd(CMD_MOVE, AX_Y, 17'd1, '0, HEADING_UP, 1'b0, 1'b0);
      wait_idle();

      // --- short homing moves
      load_profile(16'd1, 16'd0, 17'd3, 17'd2);
      push_cmd(CMD_HOME, 1'b0, '0, '0, HEADING_NONE, 1'b0, 1'b0);       // y busy, refused
      push_cmd(CMD_TICK, 1'b0, '0, '0, HEADING_NONE, 1'b0, 1'b0);
      push_cmd(CMD_TICK, 1'b0, '0, '0, HEADING_NONE, 1'b0, 1'b0);
      push_cmd(CMD_MOVE, AX_X, 17'd3, 16'd1, HEADING_LEFT, 1'b0, 1'b0);
      // x may still be on its own move: the search is dropped and the sequence waits
      push_cmd(CMD_HOME, 1'b0, '0, '0, HEADING_NONE, 1'b0, 1'b0);
      push_cmd(CMD_HOME, 1'b1, LEN_MAX, PER_MAX, HEADING_UNKNOWN, 1'b0, 1'b0);
      random_traffic(SEGMENT_BEATS);
      wait_idle();

      // --- everything zero
      load_profile('0, '0, '0, '0);
      random_traffic(SEGMENT_BEATS);
      wait_idle();

      load_profile(PER_W'($urandom_range(0, 7)), PER_W'($urandom_range(0, 7)),
                   LEN_W'($urandom_range(0, 12)), LEN_W'($urandom_range(0, 6)));
      random_traffic(SEGMENT_BEATS);
      wait_idle();

      // --- full-scale search period: searches end only through endstop stops
      load_profile(PER_MAX, 16'd3, 17'd4, 17'd1);
      random_traffic(SEGMENT_BEATS);
      wait_idle();

      // --- full-scale search length
      load_profile(16'd2, 16'd1, LEN_MAX, 17'd3);
      random_traffic(SEGMENT_BEATS);
      wait_idle();

      load_profile(PER_W'($urandom_range(0, 7)), PER_W'($urandom_range(0, 7)),
                   LEN_W'($urandom_range(0, 12)), LEN_W'($urandom_range(0, 6)));
      random_traffic(SEGMENT_BEATS);
      wait_idle();

      // --- full-scale back-off; last on purpose, a back-off this long never ends here
      load_profile(16'd5, PER_MAX, 17'd1, LEN_MAX);
      random_traffic(SEGMENT_BEATS);
      wait_idle();

      $display("tb: %0d command beats, %0d results checked, %0d homing runs finished",
               beats_taken, results_checked, homing_runs);
      $display("tb: %0d endstop stops over eight register profiles, zero to full scale",
               limit_stops);
      if (err_cnt == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
